>>> hw/rtl/uxcal_pkg.sv
// uxcal_pkg: shared types, constants and the month-start table for the
// seconds-to-calendar pipeline; depends on nothing
package uxcal_pkg;

    // seconds per day split as DAY_ODD << DAY_LO_W
    localparam int DAY_LO_W = 7;
    localparam logic [9:0] DAY_ODD = 10'd675;

    // ceil(2^k / d) reciprocals; each k is large enough that the
    // truncated product equals the true quotient over the operand range
    localparam logic [25:0] RECIP_DAY  = 26'(((64'd1 << 35) + 64'd674)  / 64'd675);
    localparam logic [19:0] RECIP_1461 = 20'(((64'd1 << 30) + 64'd1460) / 64'd1461);
    localparam logic [17:0] RECIP_7    = 18'(((64'd1 << 20) + 64'd6)    / 64'd7);
    localparam logic [12:0] RECIP_153  = 13'(((64'd1 << 20) + 64'd152)  / 64'd153);
    localparam logic [18:0] RECIP_3600 = 19'(((64'd1 << 30) + 64'd3599) / 64'd3600);
    localparam logic [14:0] RECIP_60   = 15'(((64'd1 << 20) + 64'd59)   / 64'd60);
    localparam logic [21:0] RECIP_MS   = 22'(((64'd1 << 31) + 64'd999)  / 64'd1000);

    // first day count of the 400-year cycle that starts 2000-03-01
    localparam logic [14:0] CENT_DAY    = 15'd11017;
    // day count to shifted julian day, minus the century term
    localparam logic [15:0] A2_OFS_LO   = 16'd25509;
    localparam logic [15:0] A2_OFS_HI   = 16'd11016;
    localparam logic [10:0] YEAR_BASE_LO = 11'd1900;
    localparam logic [10:0] YEAR_BASE_HI = 11'd2000;
    // 1970-01-01 was a thursday
    localparam logic [14:0] WEEKDAY_EPOCH = 15'd4;
    localparam logic [9:0]  MS_MAX = 10'd999;
    localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;

    typedef struct packed {
        logic        valid;
        logic [14:0] days;
        logic [15:0] a2;
        logic        cent_hi;
        logic [16:0] rem;
        logic [9:0]  ms;
    } t_split;

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
    } t_date;

    typedef struct packed {
        logic       valid;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] ms;
    } t_tod;

    // (153 * m - 457) / 5 for march-based months 3..14
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        unique case (m)
            4'd3:    v = 9'd0;
            4'd4:    v = 9'd31;
            4'd5:    v = 9'd61;
            4'd6:    v = 9'd92;
            4'd7:    v = 9'd122;
            4'd8:    v = 9'd153;
            4'd9:    v = 9'd184;
            4'd10:   v = 9'd214;
            4'd11:   v = 9'd245;
            4'd12:   v = 9'd275;
            4'd13:   v = 9'd306;
            4'd14:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/unix_seconds_to_calendar.sv
// unix_seconds_to_calendar: top level, local-offset register and the
// seven-stage conversion pipeline; depends on uxcal_pkg, uxcal_split,
// uxcal_date and uxcal_tod
//
//   channel   handshake                  payload
//   -------   -------------------------  -----------------------------------
//   input     start / busy               i_utc_seconds, i_micro_seconds
//   config    i_cfg_valid / o_cfg_ready  i_cfg_local_offset_sec
//   result    o_strobe (one cycle)       o_year .. o_milli_seconds
//
// an item enters on every cycle that start is high; busy stays low since
// each stage passes its item on in the next cycle
// the result passes seven registered stages: offset add and clamp, the day
// split multiply, the remainder, then for date and time of day a reciprocal
// multiply, a remainder, a second multiply and a fold-back or remainder stage
// the receiver cannot hold results off, so there is no stall path
// synchronous active-low reset clears the valid chain and the offset
module unix_seconds_to_calendar
    import uxcal_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               start,
    output logic               busy,
    input  logic [30:0]        i_utc_seconds,
    input  logic [19:0]        i_micro_seconds,
    // configuration write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic signed [16:0] i_cfg_local_offset_sec,
    // result items
    output logic               o_strobe,
    output logic [10:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day_of_month,
    output logic [2:0]         o_weekday,
    output logic [4:0]         o_hour,
    output logic [5:0]         o_minute,
    output logic [5:0]         o_second,
    output logic [9:0]         o_milli_seconds
);

    // local-time offset, two's complement seconds
    logic [16:0] r_offset;
    logic [16:0] n_offset;

    t_split w_split;
    t_date  w_date;
    t_tod   w_tod;

    // the pipeline never stalls, and config writes are always taken
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign n_offset = (i_cfg_valid && o_cfg_ready) ? i_cfg_local_offset_sec : r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

    // stages 1-3: clamp, days / seconds of day, milliseconds
    uxcal_split u_split (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start && !busy),
        .i_utc_seconds   (i_utc_seconds),
        .i_micro_seconds (i_micro_seconds),
        .i_offset        (r_offset),
        .o_split         (w_split)
    );

    // stages 4-7: calendar date; weekday from the day count, which matches
    // the month-table formula for every date in range
    uxcal_date u_date (
        .i_clk   (i_clk),
        .i_split (w_split),
        .o_date  (w_date)
    );

    // stages 4-7: time of day, carries the item valid
    uxcal_tod u_tod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_split (w_split),
        .o_tod   (w_tod)
    );

    assign o_strobe        = w_tod.valid;
    assign o_year          = w_date.year;
    assign o_month         = w_date.month;
    assign o_day_of_month  = w_date.day;
    assign o_weekday       = w_date.weekday;
    assign o_hour          = w_tod.hour;
    assign o_minute        = w_tod.minute;
    assign o_second        = w_tod.second;
    assign o_milli_seconds = w_tod.ms;

`ifndef SYNTHESIS
    // every accepted item comes out as a result strobe
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_strobe)
        else $error("accepted item did not come out after seven cycles");

    // no result strobe without a matching accepted item
    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 7))
        else $error("result strobe without a matching accepted item");

    // the clamped range keeps every field inside its calendar bounds
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_year >= 11'd1970 && o_year <= 11'd2038 &&
                      o_month >= 4'd1 && o_month <= 4'd12 &&
                      o_day_of_month != 5'd0 && o_weekday != 3'd7 &&
                      o_hour <= 5'd23 && o_minute <= 6'd59 &&
                      o_second <= 6'd59 && o_milli_seconds <= 10'd999))
        else $error("result field outside its calendar range");
`endif

endmodule

>>> hw/rtl/uxcal_split.sv
// uxcal_split: stages 1-3, offset add and clamp, split into days and
// seconds of day, millisecond quotient; depends on uxcal_pkg
module uxcal_split
    import uxcal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [30:0] i_utc_seconds,
    input  logic [19:0] i_micro_seconds,
    input  logic [16:0] i_offset,
    output t_split      o_split
);

    logic        r_s1_valid, r_s2_valid, r_s3_valid;
    logic [30:0] r_s1_local;
    logic [19:0] r_s1_usec;
    logic [49:0] r_s2_prod_day;
    logic [23:0] r_s2_hi;
    logic [6:0]  r_s2_lo;
    logic [41:0] r_s2_prod_ms;
    logic [14:0] r_s3_days;
    logic [15:0] r_s3_a2;
    logic        r_s3_cent_hi;
    logic [16:0] r_s3_rem;
    logic [9:0]  r_s3_ms;

    logic [32:0] w_sum;
    logic [30:0] n_local;
    logic [14:0] n_days;
    logic [23:0] w_hi_rem;
    logic        n_cent_hi;
    logic [15:0] n_a2;
    logic [10:0] w_ms_q;
    logic [9:0]  n_ms;

    // stage 1: local = utc + offset, clamped to [0, 2^31-1]
    assign w_sum = {2'b00, i_utc_seconds} + {{16{i_offset[16]}}, i_offset};

    always_comb begin
        priority if (w_sum[32]) begin
            n_local = '0;
        end else if (w_sum[31]) begin
            n_local = '1;
        end else begin
            n_local = w_sum[30:0];
        end
    end

    // stage 3: quotient, remainder, julian-day prep
    assign n_days   = r_s2_prod_day[49:35];
    assign w_hi_rem = r_s2_hi - 24'(n_days) * 24'(DAY_ODD);
    assign n_cent_hi = (n_days >= CENT_DAY);
    assign n_a2     = n_cent_hi ? (16'(n_days) - A2_OFS_HI) : (16'(n_days) + A2_OFS_LO);
    assign w_ms_q   = r_s2_prod_ms[41:31];
    assign n_ms     = (w_ms_q > 11'(MS_MAX)) ? MS_MAX : w_ms_q[9:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_local    <= n_local;
        r_s1_usec     <= i_micro_seconds;
        r_s2_prod_day <= 50'(r_s1_local[30:DAY_LO_W]) * 50'(RECIP_DAY);
        r_s2_hi       <= r_s1_local[30:DAY_LO_W];
        r_s2_lo       <= r_s1_local[DAY_LO_W-1:0];
        r_s2_prod_ms  <= 42'(r_s1_usec) * 42'(RECIP_MS);
        r_s3_days     <= n_days;
        r_s3_a2       <= n_a2;
        r_s3_cent_hi  <= n_cent_hi;
        r_s3_rem      <= {w_hi_rem[9:0], r_s2_lo};
        r_s3_ms       <= n_ms;
    end

    assign o_split = '{valid:   r_s3_valid,
                       days:    r_s3_days,
                       a2:      r_s3_a2,
                       cent_hi: r_s3_cent_hi,
                       rem:     r_s3_rem,
                       ms:      r_s3_ms};

endmodule

>>> hw/rtl/uxcal_date.sv
// uxcal_date: stages 4-7, julian day to year, month, day and weekday;
// depends on uxcal_pkg
module uxcal_date
    import uxcal_pkg::*;
(
    input  logic   i_clk,
    input  t_split i_split,
    output t_date  o_date
);

    logic [37:0] r_s4_py;
    logic [32:0] r_s4_pw;
    logic [15:0] r_s4_a2;
    logic        r_s4_cent_hi;
    logic [14:0] r_s4_wx;
    logic [6:0]  r_s5_y, r_s6_y;
    logic [8:0]  r_s5_a3, r_s6_a3;
    logic        r_s5_cent_hi, r_s6_cent_hi;
    logic [2:0]  r_s5_wd, r_s6_wd;
    logic [23:0] r_s6_pm;
    t_date       r_s7_date;

    logic [17:0] w_num_y;
    logic [14:0] w_wx;
    logic [6:0]  n_y;
    logic [15:0] w_a3;
    logic [11:0] w_q7;
    logic [14:0] w_wd;
    logic [10:0] w_num_m;
    logic [3:0]  w_m;
    logic        w_wrap;
    logic [8:0]  w_day;
    t_date       n_date;

    // stage 4: (4a - 1) / 1461 and weekday quotient products
    assign w_num_y = {i_split.a2, 2'b00} - 18'd1;
    assign w_wx    = i_split.days + WEEKDAY_EPOCH;

    // stage 5: year of the cycle, day of the march-based year, weekday
    assign n_y  = r_s4_py[36:30];
    assign w_a3 = r_s4_a2 - 16'((18'(n_y) * 18'd1461) >> 2);
    assign w_q7 = r_s4_pw[31:20];
    assign w_wd = r_s4_wx - 15'(w_q7) * 15'd7;

    // stage 6: (5a - 3) / 153 product
    assign w_num_m = 11'(r_s5_a3) * 11'd5 - 11'd3;

    // stage 7: month, day and year fold-back
    assign w_m    = r_s6_pm[23:20] + 4'd3;
    assign w_wrap = (w_m > MONTHS_PER_YEAR);
    assign w_day  = r_s6_a3 - month_start(w_m);

    always_comb begin
        n_date.month   = w_wrap ? (w_m - MONTHS_PER_YEAR) : w_m;
        n_date.year    = (r_s6_cent_hi ? YEAR_BASE_HI : YEAR_BASE_LO)
                         + 11'(r_s6_y) + 11'(w_wrap);
        n_date.day     = w_day[4:0];
        n_date.weekday = r_s6_wd;
    end

    always_ff @(posedge i_clk) begin
        r_s4_py      <= 38'(w_num_y) * 38'(RECIP_1461);
        r_s4_pw      <= 33'(w_wx) * 33'(RECIP_7);
        r_s4_a2      <= i_split.a2;
        r_s4_cent_hi <= i_split.cent_hi;
        r_s4_wx      <= w_wx;
        r_s5_y       <= n_y;
        r_s5_a3      <= w_a3[8:0];
        r_s5_cent_hi <= r_s4_cent_hi;
        r_s5_wd      <= w_wd[2:0];
        r_s6_pm      <= 24'(w_num_m) * 24'(RECIP_153);
        r_s6_y       <= r_s5_y;
        r_s6_a3      <= r_s5_a3;
        r_s6_cent_hi <= r_s5_cent_hi;
        r_s6_wd      <= r_s5_wd;
        r_s7_date    <= n_date;
    end

    assign o_date = r_s7_date;

endmodule

>>> hw/rtl/uxcal_tod.sv
// uxcal_tod: stages 4-7, seconds of day to hour, minute, second, with the
// item valid chain and milliseconds riding along; depends on uxcal_pkg
module uxcal_tod
    import uxcal_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_split i_split,
    output t_tod   o_tod
);

    logic        r_s4_valid, r_s5_valid, r_s6_valid, r_s7_valid;
    logic [35:0] r_s4_ph;
    logic [16:0] r_s4_rem;
    logic [9:0]  r_s4_ms, r_s5_ms, r_s6_ms, r_s7_ms;
    logic [4:0]  r_s5_hour, r_s6_hour, r_s7_hour;
    logic [11:0] r_s5_r2, r_s6_r2;
    logic [26:0] r_s6_pmin;
    logic [5:0]  r_s7_minute, r_s7_second;

    logic [4:0]  n_hour;
    logic [16:0] w_r2;
    logic [5:0]  n_minute;
    logic [11:0] w_sec;

    assign n_hour   = r_s4_ph[34:30];
    assign w_r2     = r_s4_rem - 17'(n_hour) * 17'd3600;
    assign n_minute = r_s6_pmin[25:20];
    assign w_sec    = r_s6_r2 - 12'(n_minute) * 12'd60;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
        end else begin
            r_s4_valid <= i_split.valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_ph     <= 36'(i_split.rem) * 36'(RECIP_3600);
        r_s4_rem    <= i_split.rem;
        r_s4_ms     <= i_split.ms;
        r_s5_hour   <= n_hour;
        r_s5_r2     <= w_r2[11:0];
        r_s5_ms     <= r_s4_ms;
        r_s6_pmin   <= 27'(r_s5_r2) * 27'(RECIP_60);
        r_s6_r2     <= r_s5_r2;
        r_s6_hour   <= r_s5_hour;
        r_s6_ms     <= r_s5_ms;
        r_s7_hour   <= r_s6_hour;
        r_s7_minute <= n_minute;
        r_s7_second <= w_sec[5:0];
        r_s7_ms     <= r_s6_ms;
    end

    assign o_tod = '{valid:  r_s7_valid,
                     hour:   r_s7_hour,
                     minute: r_s7_minute,
                     second: r_s7_second,
                     ms:     r_s7_ms};

endmodule
